// ===== hw/rtl/tkst_pkg.sv =====
// ----------------------------------------------------------------------------
// tkst_pkg
// types and codes shared by the two-key session table modules
// ----------------------------------------------------------------------------
package tkst_pkg;

	typedef enum logic [1:0] {
		FN_ADD         = 2'd0,
		FN_REMOVE      = 2'd1,
		FN_SOCK_OF_USR = 2'd2,
		FN_USR_OF_SOCK = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} rsp_status_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] user_id;
		logic [15:0] socket_id;
	} req_t;

	typedef struct packed {
		rsp_status_t status;
		logic [31:0] found_user;
		logic [15:0] found_socket;
		logic [7:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] user;
		logic [15:0] sock;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_HIT,
		S_MISS,
		S_FULL,
		S_MOVE
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic rd_last;
		logic upd;
		logic append;
		logic move;
		logic res_rec;
		logic res_miss;
		logic res_full;
	} cmd_t;

	typedef struct packed {
		func_t op;
		logic  hit;
		logic  miss;
		logic  full;
		logic  out_free;
	} sts_t;

endpackage

// ===== hw/rtl/tkst_ram.sv =====
// ----------------------------------------------------------------------------
// tkst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tkst_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/tkst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkst_ctrl
// sequencer for scan, update, append and swap-remove of the session table
// ----------------------------------------------------------------------------
module tkst_ctrl import tkst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.op == FN_ADD && sts.full) begin
					state_d = S_FULL;
				end else begin
					cmd.scan = 1'b1;
					if (sts.hit) begin
						state_d = S_HIT;
					end else if (sts.miss) begin
						state_d = S_MISS;
					end
				end
			end
			S_FULL: begin
				if (sts.out_free) begin
					cmd.res_full = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_HIT: begin
				case (sts.op)
					FN_ADD: begin
						if (sts.out_free) begin
							cmd.upd = 1'b1;
							state_d = S_IDLE;
						end
					end
					FN_REMOVE: begin
						cmd.rd_last = 1'b1;
						state_d     = S_MOVE;
					end
					default: begin
						if (sts.out_free) begin
							cmd.res_rec = 1'b1;
							state_d     = S_IDLE;
						end
					end
				endcase
			end
			S_MISS: begin
				if (sts.out_free) begin
					if (sts.op == FN_ADD) begin
						cmd.append = 1'b1;
					end else begin
						cmd.res_miss = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_MOVE: begin
				if (sts.out_free) begin
					cmd.move = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/tkst_datapath.sv =====
// ----------------------------------------------------------------------------
// tkst_datapath
// table storage, scan pipeline, entry count and result register
// ----------------------------------------------------------------------------
module tkst_datapath import tkst_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	func_t         op_q;
	logic [31:0]   uid_q;
	logic [15:0]   sid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] last_cnt;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] hit_addr_q;
	entry_t        rec_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          res_load;

	logic          issue;
	logic          match;
	logic          hit;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	entry_t        rd_ent;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_ent;

	tkst_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_ent   = rd_data;
	assign last_cnt = count_q - CW'(1);
	assign issue    = cmd.scan && (idx_q < count_q);

	always_comb begin
		case (op_q)
			FN_ADD:         match = (rd_ent.user == uid_q) || (rd_ent.sock == sid_q);
			FN_SOCK_OF_USR: match = (rd_ent.user == uid_q);
			default:        match = (rd_ent.sock == sid_q);
		endcase
	end

	assign hit = pend_s1 && match;

	assign sts.op       = op_q;
	assign sts.hit      = hit;
	assign sts.miss     = !pend_s1 && !(idx_q < count_q);
	assign sts.full     = (count_q == CW'(TABLE_DEPTH));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	assign rd_en   = issue || cmd.rd_last;
	assign rd_addr = cmd.rd_last ? last_cnt[AW-1:0] : idx_q[AW-1:0];

	always_comb begin
		wr_en   = cmd.upd || cmd.append || cmd.move;
		wr_addr = hit_addr_q;
		wr_ent  = rd_ent;
		count_d = count_q;
		if (cmd.upd) begin
			wr_ent.user = rec_q.user;
			wr_ent.sock = sid_q;
		end else if (cmd.append) begin
			wr_addr     = count_q[AW-1:0];
			wr_ent.user = uid_q;
			wr_ent.sock = sid_q;
			count_d     = count_q + CW'(1);
		end else if (cmd.move) begin
			count_d = last_cnt;
		end
	end

	always_comb begin
		res_load = cmd.upd || cmd.append || cmd.move || cmd.res_rec ||
			cmd.res_miss || cmd.res_full;
		rsp_d.status       = ST_OK;
		rsp_d.found_user   = rec_q.user;
		rsp_d.found_socket = rec_q.sock;
		rsp_d.entry_count  = 8'(count_d);
		if (cmd.upd) begin
			rsp_d.found_socket = sid_q;
		end else if (cmd.append) begin
			rsp_d.found_user   = uid_q;
			rsp_d.found_socket = sid_q;
		end else if (cmd.res_miss || cmd.res_full) begin
			rsp_d.status       = cmd.res_full ? ST_FULL : ST_MISSING;
			rsp_d.found_user   = '0;
			rsp_d.found_socket = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.start) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				idx_q   <= idx_q + CW'(issue);
				pend_s1 <= issue;
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= req.func;
			uid_q <= req.user_id;
			sid_q <= req.socket_id;
		end
		if (cmd.scan) begin
			addr_s1 <= idx_q[AW-1:0];
			if (hit) begin
				hit_addr_q <= addr_s1;
				rec_q      <= rd_ent;
			end
		end
		if (res_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/two_key_session_table_unit.sv =====
// ----------------------------------------------------------------------------
// two_key_session_table_unit
// unsorted table of (user id, socket id) pairs with add, swap-remove and
// lookups by either key
// ----------------------------------------------------------------------------
// usage
//   req channel: one item is an operation (func, user_id, socket_id); it is
//   taken when req_valid is high and req_stall is low. req_stall stays high
//   from the cycle after an item is taken until its result is loaded.
//   rsp channel: one result item per request (status, found_user,
//   found_socket, entry_count), held in an output register until taken.
//   timing: the table sits in a single-port-read ram, scanned one entry per
//   cycle from slot 0; a scan stops at the first match. a remove adds a
//   read of the last entry after the match; an add to a full table is
//   refused without a scan.
//   reset: the entry count clears at once, no clearing pass; slots at or
//   above the count are never read.
//   stall: a finished result waits in its state until the output register is
//   free; a new request is taken while the previous result is still pending.
// ----------------------------------------------------------------------------
module two_key_session_table_unit import tkst_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	tkst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tkst_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for two_key_session_table_unit. An in-bench copy of
// the session table predicts the result of every accepted request item.
// Results are checked field by field, in order, against those predictions.
// The tests cover the empty table, adds that append or update, swap-removes,
// a full table and a long output stall. A long random run follows. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module testbench import tkst_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 128;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [31:0] users[DEPTH];
	logic [15:0] socks[DEPTH];
	int occupancy = 0;
	rsp_t owed_results[$];
	int mismatches = 0;
	bit calm = 1'b0;
	logic long_hold = 1'b0;
	int hold_left = 0;
	int unsigned fresh_tag = 0;

	two_key_session_table_unit #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic rsp_t apply_to_table(req_t item);
		rsp_t r;
		int hit;
		int last;
		r = '0;
		r.status = ST_MISSING;
		hit = -1;
		case (item.func)
			FN_ADD: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = 0; i < occupancy && hit < 0; i++)
						if (users[i] == item.user_id || socks[i] == item.socket_id)
							hit = i;
					if (hit >= 0) begin
						socks[hit] = item.socket_id;
						r.found_user = users[hit];
					end else begin
						users[occupancy] = item.user_id;
						socks[occupancy] = item.socket_id;
						occupancy++;
						r.found_user = item.user_id;
					end
					r.found_socket = item.socket_id;
					r.status = ST_OK;
				end
			end
			FN_SOCK_OF_USR: begin
				for (int i = 0; i < occupancy && hit < 0; i++)
					if (users[i] == item.user_id)
						hit = i;
			end
			default: begin
				for (int i = 0; i < occupancy && hit < 0; i++)
					if (socks[i] == item.socket_id)
						hit = i;
			end
		endcase
		if (item.func != FN_ADD && hit >= 0) begin
			r.status = ST_OK;
			r.found_user = users[hit];
			r.found_socket = socks[hit];
			if (item.func == FN_REMOVE) begin
				last = occupancy - 1;
				users[hit] = users[last];
				socks[hit] = socks[last];
				occupancy = last;
			end
		end
		r.entry_count = occupancy[7:0];
		return r;
	endfunction

	task automatic issue(input func_t op, input logic [31:0] uid, input logic [15:0] sid);
		req_t item;
		item.func = op;
		item.user_id = uid;
		item.socket_id = sid;
		if (!calm)
			while ($urandom_range(99) < 31) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		owed_results.push_back(apply_to_table(item));
	endtask

	task automatic pause_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (owed_results.size() == 0) begin
			$error("result item with nothing expected: %h", got);
			mismatches++;
			return;
		end
		want = owed_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			mismatches++;
		end
		if (got.found_user !== want.found_user) begin
			$error("found_user: expected %h, actual %h", want.found_user, got.found_user);
			mismatches++;
		end
		if (got.found_socket !== want.found_socket) begin
			$error("found_socket: expected %h, actual %h", want.found_socket,
				got.found_socket);
			mismatches++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, actual %0d", want.entry_count,
				got.entry_count);
			mismatches++;
		end
	endtask

	// receiver side, with the long hold counted here
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			check_result(rsp);
		if (long_hold && hold_left == 0) begin
			hold_left = 400;
			long_hold <= 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm && ($urandom_range(99) < 31);
		end
	end

	function automatic logic [31:0] pick_user();
		int unsigned r;
		r = $urandom_range(99);
		if (occupancy != 0 && r < 50)
			return users[$urandom_range(occupancy - 1)];
		if (r < 85)
			return 32'($urandom_range(300));
		return $urandom();
	endfunction

	function automatic logic [15:0] pick_socket();
		int unsigned r;
		r = $urandom_range(99);
		if (occupancy != 0 && r < 50)
			return socks[$urandom_range(occupancy - 1)];
		if (r < 85)
			return 16'($urandom_range(300));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic add_fresh();
		fresh_tag++;
		issue(FN_ADD, 32'h5A00_0000 | fresh_tag, 16'h8000 | 16'(fresh_tag));
	endtask

	task automatic test_empty_table();
		issue(FN_SOCK_OF_USR, 32'h0000_0000, 16'h0000);
		issue(FN_SOCK_OF_USR, 32'hFFFF_FFFF, 16'hFFFF);
		issue(FN_USR_OF_SOCK, 32'h0000_0000, 16'hFFFF);
		issue(FN_USR_OF_SOCK, 32'hFFFF_FFFF, 16'h0000);
		issue(FN_REMOVE, 32'h0000_0000, 16'h0000);
	endtask

	task automatic test_add_and_lookup();
		issue(FN_ADD, 32'h0000_0000, 16'h0000);
		issue(FN_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		issue(FN_ADD, 32'h1234_5678, 16'h00AA);
		// update by user, then by socket
		issue(FN_ADD, 32'hFFFF_FFFF, 16'h1234);
		issue(FN_ADD, 32'hCAFE_0001, 16'h00AA);
		// user matches a later slot, socket the first one
		issue(FN_ADD, 32'h1234_5678, 16'h0000);
		issue(FN_SOCK_OF_USR, 32'hFFFF_FFFF, 16'h0000);
		issue(FN_USR_OF_SOCK, 32'h0000_0000, 16'h00AA);
		issue(FN_USR_OF_SOCK, 32'hFFFF_FFFF, 16'h0000);
		issue(FN_SOCK_OF_USR, 32'h0000_0005, 16'hFFFF);
		issue(FN_ADD, 32'h0BAD_F00D, 16'h7777);
	endtask

	task automatic test_swap_remove();
		issue(FN_REMOVE, 32'h0, 16'h1234);
		issue(FN_REMOVE, 32'h0, 16'h00AA);
		issue(FN_REMOVE, 32'h0, 16'h5555);
		issue(FN_USR_OF_SOCK, 32'h0, 16'h7777);
		issue(FN_REMOVE, 32'h0, 16'h0000);
		issue(FN_REMOVE, 32'h0, 16'h7777);
		issue(FN_REMOVE, 32'h0, 16'h7777);
	endtask

	task automatic test_full_table();
		calm = 1'b1;
		while (occupancy < DEPTH / 2)
			add_fresh();
		calm = 1'b0;
		while (occupancy < DEPTH)
			add_fresh();
		add_fresh();
		issue(FN_ADD, users[0], socks[5]);
		issue(FN_SOCK_OF_USR, users[DEPTH - 1], 16'h0);
		issue(FN_USR_OF_SOCK, 32'h0, 16'h0001);
		issue(FN_REMOVE, 32'h0, socks[0]);
		add_fresh();
		issue(FN_REMOVE, 32'h0, socks[DEPTH - 1]);
	endtask

	task automatic test_output_stall();
		pause_until_drained();
		long_hold <= 1'b1;
		calm = 1'b1;
		repeat (8)
			issue(func_t'($urandom_range(3)), pick_user(), pick_socket());
		calm = 1'b0;
		pause_until_drained();
	endtask

	task automatic test_random_traffic();
		int unsigned add_pct;
		int unsigned r;
		func_t op;
		for (int chunk = 0; chunk < 8; chunk++) begin
			case ($urandom_range(3))
				0: add_pct = 20;
				1: add_pct = 45;
				2: add_pct = 70;
				default: add_pct = 90;
			endcase
			calm = (chunk == 3);
			repeat (50) begin
				r = $urandom_range(99);
				if (r < add_pct)
					op = FN_ADD;
				else if (r < add_pct + (100 - add_pct) / 2)
					op = FN_REMOVE;
				else if (r[0])
					op = FN_SOCK_OF_USR;
				else
					op = FN_USR_OF_SOCK;
				issue(op, pick_user(), pick_socket());
			end
			if ($urandom_range(2) == 0)
				pause_until_drained();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_add_and_lookup();
		test_swap_remove();
		test_full_table();
		test_output_stall();
		test_random_traffic();
		pause_until_drained();
		repeat (140) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
